### design/sorted_position_map_floor_lookup_defines.svh
// assertion macros for the sorted position map
`ifndef SORTED_POSITION_MAP_FLOOR_LOOKUP_DEFINES_SVH
`define SORTED_POSITION_MAP_FLOOR_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("spm assertion failed");
`define SPM_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("spm assertion failed");
`else
`define SPM_ASSERT_IMP(label, clk, rst, a, c)
`define SPM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### design/spm_pkg.sv
// shared types and codes for the sorted position map
`default_nettype none
package spm_pkg;
   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned POSITION_BITS_DEF = 48;
   localparam int unsigned POS_W = 48;
   localparam int unsigned ROOT_W = 4;
   localparam int unsigned KIND_W = 4;
   localparam int unsigned COUNT_W = 7;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0, CMD_REMOVE = 2'd1, CMD_LOOKUP = 2'd2, CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2, ST_REPLACED = 2'd3
   } status_type;
endpackage
`default_nettype wire

### design/spm_table_ram.sv
// entry table memory: one write port, one registered read port
`default_nettype none
module spm_table_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 56
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/sorted_position_map_floor_lookup.sv
// top level of the sorted position map with floor lookup
//
// one command per transaction on the req_ ports: add or update, remove,
// floor lookup or clear. a command is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with rsp_valid.
// the entries live in one synchronous ram with one read and one write port.
// a search walks the table from index zero, one entry per cycle through the
// registered read port, stopping at the first position not below (add,
// remove) or above (lookup) the key. an insert or remove then shifts the
// tail one entry at a time, with a read state then a write state per entry.
// a clear is answered in the cycle after it is taken. an insert moves
// count-n entries and a remove count-n-1, where n is the stopping index
// (count when the search runs past the last entry). busy drops in the
// cycle the result is shown, so the next command can be taken at the
// edge that ends it.
// reset empties the table (count to zero); the ram itself is not cleared,
// entries at or beyond the count are never used.
// the receiver cannot stall: the result is shown once and is gone.
`default_nettype none
`include "sorted_position_map_floor_lookup_defines.svh"
module sorted_position_map_floor_lookup
   import spm_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF,
   parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [ROOT_W-1:0]  req_root_pitch,
   input  wire logic [KIND_W-1:0]  req_key_kind,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [ROOT_W-1:0]       rsp_found_root,
   output logic [KIND_W-1:0]       rsp_found_kind,
   output logic [COUNT_W-1:0]      rsp_entry_count
);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned EW = POSITION_BITS + ROOT_W + KIND_W;
   localparam int unsigned KW = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_WAIT, S_SHIFT_RD, S_SHIFT_WR, S_FINISH
   } state_type;

   state_type         state_ff;
   logic [1:0]        cmd_ff;
   logic [POSITION_BITS-1:0] key_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     idx_ff;      // index whose data arrives next cycle
   logic [CW-1:0]     hit_ff;      // stopping index of the search
   logic [CW-1:0]     sh_ff;       // shift pointer
   logic              rd_pend_ff;  // a read was issued last cycle
   logic              match_ff;    // stopping entry holds the key exactly
   logic [1:0]        status_ff;
   logic [ROOT_W-1:0] froot_ff;
   logic [KIND_W-1:0] fkind_ff;
   logic [EW-1:0]     prev_ff;     // entry just before the stopping index, read during search
   logic              rsp_valid_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [EW-1:0]     wr_data;
   logic [AW-1:0]     rd_addr;
   logic [EW-1:0]     rd_data;
   logic [EW-1:0]     new_entry;
   logic [POSITION_BITS-1:0] rd_pos;
   logic              stop_here;
   logic              clear_take;

   assign new_entry = {key_ff, root_ff, kind_ff};
   assign rd_pos = rd_data[EW-1 -: POSITION_BITS];
   assign stop_here = (cmd_ff == CMD_LOOKUP) ? (rd_pos > key_ff) : (rd_pos >= key_ff);
   assign clear_take = start && !busy && (req_command == CMD_CLEAR);

   spm_table_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // memory address and write control
   always_comb begin
      wr_en = 1'b0;
      wr_addr = sh_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_SHIFT_RD: begin
            // insert reads sh-1 to move it up; remove reads sh+1 to move down
            rd_addr = (cmd_ff == CMD_ADD) ? AW'(sh_ff - CW'(1)) : AW'(sh_ff + CW'(1));
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         S_FINISH: begin
            wr_en = (cmd_ff == CMD_ADD) && (status_ff != ST_FULL);
            wr_addr = hit_ff[AW-1:0];
            wr_data = new_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff <= req_command;
                  key_ff <= POSITION_BITS'(req_position[KW-1:0]);
                  root_ff <= req_root_pitch;
                  kind_ff <= req_key_kind;
                  idx_ff <= '0;
                  rd_pend_ff <= 1'b0;
                  froot_ff <= '0;
                  fkind_ff <= '0;
                  status_ff <= ST_OK;
                  if (req_command == CMD_CLEAR) begin
                     count_ff <= '0;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_SEARCH;
                  end
               end
            end
            S_SEARCH: begin
               // rd_data holds entry idx_ff-1 when rd_pend_ff is set
               if (rd_pend_ff && stop_here) begin
                  hit_ff <= idx_ff - CW'(1);
                  match_ff <= (rd_pos == key_ff);
                  state_ff <= S_WAIT;
                  rd_pend_ff <= 1'b0;
               end else if (idx_ff == count_ff) begin
                  if (rd_pend_ff) begin
                     prev_ff <= rd_data;
                  end
                  hit_ff <= idx_ff;
                  match_ff <= 1'b0;
                  state_ff <= S_WAIT;
                  rd_pend_ff <= 1'b0;
               end else begin
                  if (rd_pend_ff) begin
                     prev_ff <= rd_data;
                  end
                  idx_ff <= idx_ff + CW'(1);
                  rd_pend_ff <= 1'b1;
               end
            end
            S_WAIT: begin
               priority case (cmd_ff)
                  CMD_LOOKUP: begin
                     if (hit_ff == '0) begin
                        status_ff <= ST_MISS;
                     end else begin
                        froot_ff <= prev_ff[ROOT_W+KIND_W-1:KIND_W];
                        fkind_ff <= prev_ff[KIND_W-1:0];
                     end
                     state_ff <= S_FINISH;
                  end
                  CMD_ADD: begin
                     if (match_ff) begin
                        status_ff <= ST_REPLACED;
                        state_ff <= S_FINISH;
                     end else if (count_ff >= CW'(CAPACITY)) begin
                        status_ff <= ST_FULL;
                        state_ff <= S_FINISH;
                     end else begin
                        sh_ff <= count_ff;
                        state_ff <= (count_ff == hit_ff) ? S_FINISH : S_SHIFT_RD;
                     end
                  end
                  default: begin
                     if (match_ff) begin
                        sh_ff <= hit_ff;
                        state_ff <= (hit_ff + CW'(1) == count_ff) ? S_FINISH : S_SHIFT_RD;
                     end else begin
                        status_ff <= ST_MISS;
                        state_ff <= S_FINISH;
                     end
                  end
               endcase
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               if (cmd_ff == CMD_ADD) begin
                  sh_ff <= sh_ff - CW'(1);
                  state_ff <= (sh_ff - CW'(1) == hit_ff) ? S_FINISH : S_SHIFT_RD;
               end else begin
                  sh_ff <= sh_ff + CW'(1);
                  state_ff <= (sh_ff + CW'(2) == count_ff) ? S_FINISH : S_SHIFT_RD;
               end
            end
            S_FINISH: begin
               if (status_ff == ST_OK) begin
                  if (cmd_ff == CMD_ADD) begin
                     count_ff <= count_ff + CW'(1);
                  end else if (cmd_ff == CMD_REMOVE) begin
                     count_ff <= count_ff - CW'(1);
                  end
               end
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found_root = froot_ff;
   assign rsp_found_kind = fkind_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

   `SPM_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SPM_ASSERT_NXT(a_clear_empties, clock, reset, clear_take, rsp_valid && rsp_entry_count == '0)
   `SPM_ASSERT_IMP(a_miss_no_data, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_found_root == '0 && rsp_found_kind == '0)
endmodule
`default_nettype wire
